// ===== hw/rtl/rld_pkg.sv =====
// Shared types and constants for the run-length byte decoder.
// No dependencies; imported by every module of the block.
package rld_pkg;

  localparam int TOTAL_WIDTH_DEF = 16;
  localparam int OUT_TOTAL_W = 16;

  // Parsing modes of the compressed stream.
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_RUN     = 2'd1;
  localparam logic [1:0] MODE_LITERAL = 2'd2;

  localparam logic [1:0] NBYTES_ONE = 2'd1;
  localparam logic [1:0] NBYTES_TWO = 2'd2;

  typedef struct packed {
    logic take_header;
    logic take_literal;
    logic start_run;
    logic emit_run;
  } rld_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_free;
    logic       run_final;
  } rld_sts_t;

endpackage

// ===== hw/rtl/rld_ctrl.sv =====
// Controller for the run-length byte decoder: input handshake and run sequencing.
// Depends on rld_pkg for the command and status structs and the mode codes.
module rld_ctrl
  import rld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rld_sts_t sts,
  output rld_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic acc;

  assign in_stall = (state_r != ST_IDLE) || !sts.out_free;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (sts.mode)
            MODE_LITERAL: cmd.take_literal = 1'b1;
            MODE_RUN: begin
              cmd.start_run = 1'b1;
              state_nxt     = ST_RUN;
            end
            default: cmd.take_header = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit_run = 1'b1;
          if (sts.run_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/rld_dp.sv =====
// Datapath for the run-length byte decoder: stream state, byte counter, output register.
// Depends on rld_pkg; driven by commands from rld_ctrl.
module rld_dp
  import rld_pkg::*;
#(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_compressed_byte,
  input  logic        in_end_of_block,
  input  rld_cmd_t    cmd,
  output rld_sts_t    sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_first_byte,
  output logic [7:0]  out_second_byte,
  output logic [1:0]  out_valid_bytes,
  output logic        out_run_last,
  output logic [15:0] out_total_out
);

  localparam int SW = (TOTAL_WIDTH > OUT_TOTAL_W) ? TOTAL_WIDTH : OUT_TOTAL_W;

  logic [1:0]             mode_r, mode_nxt;
  logic [7:0]             count_r, count_nxt;
  logic [TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic [7:0]             run_byte_r, run_byte_nxt;
  logic [7:0]             run_left_r, run_left_nxt;
  logic                   run_eob_r, run_eob_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [1:0]  nbytes_r, nbytes_nxt;
  logic        last_r, last_nxt;
  logic [15:0] shown_r, shown_nxt;

  logic                   run_two;
  logic [1:0]             add_n;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] total_sat;
  logic [SW-1:0]          total_ext;
  logic [15:0]            total_shown;
  logic                   load;

  assign run_two = (run_left_r >= 8'd2);
  assign add_n   = cmd.emit_run ? (run_two ? NBYTES_TWO : NBYTES_ONE) : NBYTES_ONE;

  // Saturating add: the counter's maximum is all ones, so a carry out means overflow.
  assign sum       = {1'b0, total_r} + (TOTAL_WIDTH + 1)'(add_n);
  assign total_sat = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
  assign total_ext = SW'(total_sat);
  assign total_shown = (total_ext > SW'(16'hFFFF)) ? 16'hFFFF : total_ext[15:0];

  assign load = cmd.take_literal || cmd.emit_run;

  assign sts.mode      = mode_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.run_final = (run_left_r <= 8'd2);

  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    run_byte_nxt  = run_byte_r;
    run_left_nxt  = run_left_r;
    run_eob_nxt   = run_eob_r;
    out_valid_nxt = out_valid_r && out_stall;
    first_nxt     = first_r;
    second_nxt    = second_r;
    nbytes_nxt    = nbytes_r;
    last_nxt      = last_r;
    shown_nxt     = shown_r;

    if (cmd.take_header) begin
      count_nxt = {1'b0, in_compressed_byte[6:0]} + 8'd1;
      mode_nxt  = in_compressed_byte[7] ? MODE_RUN : MODE_LITERAL;
    end

    if (cmd.take_literal) begin
      first_nxt  = in_compressed_byte;
      second_nxt = 8'd0;
      nbytes_nxt = NBYTES_ONE;
      last_nxt   = 1'b1;
      shown_nxt  = total_shown;
      total_nxt  = total_sat;
      count_nxt  = count_r - 8'd1;
      if (count_r == 8'd1) begin
        mode_nxt = MODE_HEADER;
      end
    end

    // The run is copied out of the mode registers, which return to header parsing now.
    if (cmd.start_run) begin
      run_byte_nxt = in_compressed_byte;
      run_left_nxt = count_r;
      run_eob_nxt  = in_end_of_block;
      mode_nxt     = MODE_HEADER;
      count_nxt    = 8'd0;
    end

    if (cmd.emit_run) begin
      first_nxt    = run_byte_r;
      second_nxt   = run_two ? run_byte_r : 8'd0;
      nbytes_nxt   = add_n;
      last_nxt     = sts.run_final;
      shown_nxt    = total_shown;
      total_nxt    = total_sat;
      run_left_nxt = run_left_r - 8'(add_n);
      if (sts.run_final && run_eob_r) begin
        total_nxt = '0;
      end
    end

    // End of block clears the stream state once this byte has been handled.
    if ((cmd.take_header || cmd.take_literal) && in_end_of_block) begin
      mode_nxt  = MODE_HEADER;
      count_nxt = 8'd0;
      total_nxt = '0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_HEADER;
      count_r     <= 8'd0;
      total_r     <= '0;
      run_left_r  <= 8'd0;
      run_eob_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      run_left_r  <= run_left_nxt;
      run_eob_r   <= run_eob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    nbytes_r   <= nbytes_nxt;
    last_r     <= last_nxt;
    shown_r    <= shown_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_first_byte  = first_r;
  assign out_second_byte = second_r;
  assign out_valid_bytes = nbytes_r;
  assign out_run_last    = last_r;
  assign out_total_out   = shown_r;

  a_emit_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_run |-> run_left_r != 8'd0)
    else $error("run emission with no bytes left");

  a_run_count_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_run |-> (count_r != 8'd0 && count_r <= 8'd128))
    else $error("run started with an out-of-range copy count");

  a_one_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && nbytes_r == NBYTES_ONE) |-> second_r == 8'd0)
    else $error("second byte not cleared on a one-byte result");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !in_end_of_block && !(cmd.emit_run && sts.run_final && run_eob_r))
      |=> (total_r != '0 && shown_r != 16'd0))
    else $error("byte counter zero after producing a result");

endmodule

// ===== hw/rtl/run_length_byte_decoder.sv =====
// Top level of the run-length byte decoder (header-coded byte stream expansion).
// Depends on rld_pkg, rld_ctrl and rld_dp.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  compressed_byte, end_of_block
//   out_      output     out_valid/out_stall  first_byte, second_byte, valid_bytes,
//                                             run_last, total_out
//
// A header or literal byte is handled as it is taken; a literal's result sits in the output
// register while the next byte is taken, as long as the consumer keeps up.
// A run value is latched first, then expanded into two-byte results (one byte for an odd
// remainder), paced by the single output register; input stalls throughout.
// Reset (rst_n low, synchronous) returns to header parsing with the byte count at zero.
// A stall on the result channel holds the output register and stalls the input.
module run_length_byte_decoder
  import rld_pkg::*;
#(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_compressed_byte,
  input  logic        in_end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_first_byte,
  output logic [7:0]  out_second_byte,
  output logic [1:0]  out_valid_bytes,
  output logic        out_run_last,
  output logic [15:0] out_total_out
);

  rld_cmd_t cmd;
  rld_sts_t sts;

  rld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rld_dp #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_compressed_byte (in_compressed_byte),
    .in_end_of_block    (in_end_of_block),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_first_byte     (out_first_byte),
    .out_second_byte    (out_second_byte),
    .out_valid_bytes    (out_valid_bytes),
    .out_run_last       (out_run_last),
    .out_total_out      (out_total_out)
  );

endmodule

// ===== tb/rld_scoreboard_pkg.sv =====
// Scoreboard for the run-length byte decoder testbench: expansion predictor and result checks.
// Depends on rld_pkg for the parsing modes and the byte-count width.
`timescale 1ns / 100ps
package rld_scoreboard_pkg;
  import rld_pkg::*;

  typedef struct {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [1:0]  nbytes;
    logic        last;
    logic [15:0] total;
  } expanded_word_t;

  class expansion_scoreboard;
    localparam longint unsigned COUNT_MAX = (64'd1 << TOTAL_WIDTH_DEF) - 1;
    localparam int MAX_REPORTS = 100;

    logic [1:0]      mode;
    int              left_in_stretch;
    longint unsigned emitted;
    expanded_word_t  due_words[$];
    int              mismatch_count;

    function new();
      mode = MODE_HEADER;
      left_in_stretch = 0;
      emitted = 0;
      mismatch_count = 0;
    endfunction

    // The byte count saturates, and the shown total is clamped to 16 bits.
    function void emit(logic [7:0] b0, logic [7:0] b1, int n, logic last);
      expanded_word_t w;
      emitted = (emitted + n > COUNT_MAX) ? COUNT_MAX : emitted + n;
      w.b0 = b0;
      w.b1 = (n == 2) ? b1 : 8'h00;
      w.nbytes = 2'(n);
      w.last = last;
      w.total = (emitted > 64'hFFFF) ? 16'hFFFF : 16'(emitted);
      due_words.push_back(w);
    endfunction

    function void take_byte(logic [7:0] b, logic eob);
      int copies;
      int n;
      case (mode)
        MODE_RUN: begin
          copies = left_in_stretch;
          while (copies > 0) begin
            n = (copies >= 2) ? 2 : 1;
            copies -= n;
            emit(b, b, n, copies == 0);
          end
          mode = MODE_HEADER;
          left_in_stretch = 0;
        end
        MODE_LITERAL: begin
          emit(b, 8'h00, 1, 1'b1);
          left_in_stretch--;
          if (left_in_stretch == 0) mode = MODE_HEADER;
        end
        default: begin
          left_in_stretch = b[6:0] + 1;
          mode = b[7] ? MODE_RUN : MODE_LITERAL;
        end
      endcase
      // End of block drops whatever is left of a run or stretch and clears the byte count.
      if (eob) begin
        mode = MODE_HEADER;
        left_in_stretch = 0;
        emitted = 0;
      end
    endfunction

    function void check_result(logic [7:0] b0, logic [7:0] b1, logic [1:0] nbytes,
                               logic last, logic [15:0] total);
      expanded_word_t w;
      if (due_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction, first_byte %0h total_out %0d",
                   $time, b0, total);
        return;
      end
      w = due_words.pop_front();
      if (b0 !== w.b0 || b1 !== w.b1 || nbytes !== w.nbytes || last !== w.last ||
          total !== w.total) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          if (b0 !== w.b0)
            $display("%0t: first_byte expected %0h, got %0h", $time, w.b0, b0);
          if (b1 !== w.b1)
            $display("%0t: second_byte expected %0h, got %0h", $time, w.b1, b1);
          if (nbytes !== w.nbytes)
            $display("%0t: valid_bytes expected %0d, got %0d", $time, w.nbytes, nbytes);
          if (last !== w.last)
            $display("%0t: run_last expected %0b, got %0b", $time, w.last, last);
          if (total !== w.total)
            $display("%0t: total_out expected %0d, got %0d", $time, w.total, total);
        end
      end
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction
  endclass

endpackage

// ===== tb/run_length_byte_decoder_test.sv =====
// Top-level testbench for run_length_byte_decoder: directed streams, random packets
// and output back-pressure. Depends on rld_pkg and rld_scoreboard_pkg.
`timescale 1ns / 100ps
module run_length_byte_decoder_test;
  import rld_pkg::*;
  import rld_scoreboard_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int LIMIT_CYCLES = 1_500_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_compressed_byte = 8'h00;
  logic        in_end_of_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_first_byte;
  logic [7:0]  out_second_byte;
  logic [1:0]  out_valid_bytes;
  logic        out_run_last;
  logic [15:0] out_total_out;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   bytes_sent = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  expansion_scoreboard sb = new();

  run_length_byte_decoder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_compressed_byte (in_compressed_byte),
    .in_end_of_block    (in_end_of_block),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_first_byte     (out_first_byte),
    .out_second_byte    (out_second_byte),
    .out_valid_bytes    (out_valid_bytes),
    .out_run_last       (out_run_last),
    .out_total_out      (out_total_out)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random stalls, plus one long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_first_byte, out_second_byte, out_valid_bytes, out_run_last,
                      out_total_out);
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_compressed_byte <= b;
    in_end_of_block <= eob;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, eob);
    bytes_sent++;
  endtask

  // Mostly well-formed header/payload packets with short lengths, some ending the
  // block early, plus a little raw noise. Long lengths go to runs only, so that the
  // count of bytes sent stays close to its target.
  task automatic send_random_packet();
    logic       is_run;
    logic [6:0] len;
    int         cut;
    logic       eob;
    if ($urandom_range(0, 99) < 8) begin
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    is_run = 1'($urandom_range(0, 1));
    len = (is_run && $urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 6));
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 1) : -1;
    send_byte({is_run, len}, cut == 0);
    if (cut == 0) return;
    if (is_run) begin
      send_byte(8'($urandom), $urandom_range(0, 4) == 0);
    end else begin
      for (int i = 0; i <= len; i++) begin
        eob = (i + 1 == cut) || (i == len && $urandom_range(0, 4) == 0);
        send_byte(8'($urandom), eob);
        if (eob) return;
      end
    end
  endtask

  // Bit 8 is end of block, the low byte is the compressed byte.
  logic [8:0] directed_stream [22] = '{
    9'h000, 9'h000,                 // one literal of zero
    9'h0FF, 9'h0FF,                 // longest run
    9'h080, 9'h0A5,                 // run of a single copy
    9'h081, 9'h05A,                 // run of exactly two copies
    9'h002, 9'h0FF, 9'h080, 9'h07F, // three literals
    9'h185,                         // header that closes the block
    9'h083, 9'h111,                 // run value that closes the block
    9'h005, 9'h022, 9'h133,         // literal stretch cut short
    9'h07F, 9'h001, 9'h0FE, 9'h1C3  // longest stretch cut short
  };

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 31;
    rx_idle_pct <= 65;
    foreach (directed_stream[i])
      send_byte(directed_stream[i][7:0], directed_stream[i][8]);
    while (bytes_sent < 60) send_random_packet();

    tx_idle_pct = 65;
    rx_idle_pct <= 31;
    while (bytes_sent < 105) send_random_packet();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= 1'b1;
    while (bytes_sent < 145) send_random_packet();

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0)
      $display("run_length_byte_decoder_test: PASS");
    else
      $display("run_length_byte_decoder_test: FAIL");
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("run_length_byte_decoder_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rld_pkg.sv
hw/rtl/rld_ctrl.sv
hw/rtl/rld_dp.sv
hw/rtl/run_length_byte_decoder.sv
tb/rld_scoreboard_pkg.sv
tb/run_length_byte_decoder_test.sv
